// ===== rtl/core/bgfi_pkg.sv =====
// ----------------------------------------------------------------------------
// bgfi_pkg: shared types and constants for the battery gauge filter.
// Holds the calibration tables, the sequencer state type and field widths.
// ----------------------------------------------------------------------------
package bgfi_pkg;

  localparam int SamplesPerReading = 16;
  localparam int HistoryDepth      = 8;
  localparam int CalPoints         = 11;
  localparam int CurvePoints       = 11;
  localparam int FilterScale       = SamplesPerReading * HistoryDepth;

  localparam int SampleW  = 12;
  localparam int ReadingW = 16;
  localparam int FiltW    = 19;
  localparam int CntW     = $clog2(SamplesPerReading);
  localparam int PtrW     = $clog2(HistoryDepth);
  localparam int CalIdxW  = $clog2(CalPoints);
  localparam int CurIdxW  = $clog2(CurvePoints);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HIST,
    ST_SEG,
    ST_NUM_S,
    ST_DIV_S,
    ST_NUM_B,
    ST_DIV_B,
    ST_PSEG,
    ST_PDIV,
    ST_OUT
  } state_t;

  function automatic logic [13:0] cal_adc(input logic [CalIdxW-1:0] i);
    case (i)
      4'd0: return 14'd4173;  4'd1: return 14'd4359;  4'd2: return 14'd4464;
      4'd3: return 14'd4597;  4'd4: return 14'd4740;  4'd5: return 14'd4870;
      4'd6: return 14'd5005;  4'd7: return 14'd5151;  4'd8: return 14'd5313;
      4'd9: return 14'd5435;  default: return 14'd5568;
    endcase
  endfunction

  function automatic logic [13:0] cal_sense(input logic [CalIdxW-1:0] i);
    case (i)
      4'd0: return 14'd4215;  4'd1: return 14'd4362;  4'd2: return 14'd4490;
      4'd3: return 14'd4624;  4'd4: return 14'd4761;  4'd5: return 14'd4893;
      4'd6: return 14'd5027;  4'd7: return 14'd5153;  4'd8: return 14'd5295;
      4'd9: return 14'd5427;  default: return 14'd5544;
    endcase
  endfunction

  function automatic logic [13:0] cal_batt(input logic [CalIdxW-1:0] i);
    case (i)
      4'd0: return 14'd6350;  4'd1: return 14'd6586;  4'd2: return 14'd6785;
      4'd3: return 14'd6986;  4'd4: return 14'd7193;  4'd5: return 14'd7391;
      4'd6: return 14'd7595;  4'd7: return 14'd7785;  4'd8: return 14'd7998;
      4'd9: return 14'd8199;  default: return 14'd8379;
    endcase
  endfunction

  function automatic logic [12:0] curve_mv(input logic [CurIdxW-1:0] i);
    case (i)
      4'd0: return 13'd3200;  4'd1: return 13'd3400;  4'd2: return 13'd3550;
      4'd3: return 13'd3650;  4'd4: return 13'd3720;  4'd5: return 13'd3780;
      4'd6: return 13'd3850;  4'd7: return 13'd3920;  4'd8: return 13'd4000;
      4'd9: return 13'd4100;  default: return 13'd4190;
    endcase
  endfunction

  function automatic logic [6:0] curve_pct(input logic [CurIdxW-1:0] i);
    case (i)
      4'd0: return 7'd0;   4'd1: return 7'd5;   4'd2: return 7'd10;
      4'd3: return 7'd20;  4'd4: return 7'd30;  4'd5: return 7'd40;
      4'd6: return 7'd50;  4'd7: return 7'd65;  4'd8: return 7'd80;
      4'd9: return 7'd95;  default: return 7'd100;
    endcase
  endfunction

endpackage

// ===== rtl/core/bgfi_if.sv =====
// ----------------------------------------------------------------------------
// bgfi_in_if / bgfi_out_if: valid/ready channels of the gauge.
// One transfer happens when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface bgfi_in_if;
  logic                       valid;
  logic                       ready;
  logic [bgfi_pkg::SampleW-1:0] adc_sample_mv;
  modport source (output valid, output adc_sample_mv, input ready);
  modport sink   (input valid, input adc_sample_mv, output ready);
endinterface

interface bgfi_out_if;
  logic                     valid;
  logic                     ready;
  logic [bgfi_pkg::FiltW-1:0] filtered_adc;
  logic signed [15:0]       sense_mv;
  logic signed [15:0]       battery_mv;
  logic [6:0]               charge_percent;
  logic [31:0]              reading_number;
  modport source (output valid, output filtered_adc, output sense_mv,
                  output battery_mv, output charge_percent,
                  output reading_number, input ready);
  modport sink   (input valid, input filtered_adc, input sense_mv,
                  input battery_mv, input charge_percent,
                  input reading_number, output ready);
endinterface

// ===== rtl/core/battery_gauge_filter_interp.sv =====
// ----------------------------------------------------------------------------
// battery_gauge_filter_interp: averaging filter and battery fuel gauge.
// Sums samples into readings, filters them and maps them through calibration.
// ----------------------------------------------------------------------------
// Each input transfer carries one converter sample in millivolts. Sixteen
// samples make one reading; a sample that does not complete a reading is
// added to the running sum and the block stays ready, so such samples can
// follow back to back. The sixteenth sample starts a sequenced computation:
// the eight-deep moving sum is updated (on the first reading after reset all
// eight history entries take that reading, one per cycle), then sense and
// battery millivolts are interpolated from the calibration table and the
// battery voltage is mapped to a charge percentage. The segment search walks
// the calibration table one point per cycle. Sense and battery each use one
// shared restoring divider, which latches its operands on start and then
// produces one quotient bit per cycle. The charge curve search steps through
// the curve point by point; below the curve it ends at zero percent and
// above it at full charge, otherwise a division follows the search. After a
// completing sample the block accepts no new sample until the result
// transfer has happened. Sustained throughput is set by the sequenced
// computation, averaged over the sixteen samples of each reading.
module battery_gauge_filter_interp (
  input  logic       clk,
  input  logic       rst,
  bgfi_in_if.sink    in_ch,
  bgfi_out_if.source out_ch
);

  bgfi_pkg::state_t state, state_next;

  logic [bgfi_pkg::ReadingW-1:0] sample_sum;
  logic [bgfi_pkg::CntW-1:0]     sample_count;
  logic [bgfi_pkg::ReadingW-1:0] reading_history [bgfi_pkg::HistoryDepth];
  logic [bgfi_pkg::FiltW-1:0]    history_sum;
  logic [bgfi_pkg::PtrW-1:0]     history_pointer;
  logic                          primed;
  logic [31:0]                   reading_counter;

  logic [bgfi_pkg::ReadingW-1:0] reading;
  logic [bgfi_pkg::PtrW-1:0]     fill_idx;
  logic [bgfi_pkg::CalIdxW-1:0]  seg;
  logic [bgfi_pkg::CurIdxW-1:0]  pseg;
  logic                          neg;
  logic                          pct_const;

  logic signed [15:0] sense_r;
  logic signed [15:0] batt_r;
  logic [6:0]         pct_r;
  logic               out_valid;

  // Divider hookup.
  logic        div_start;
  logic        div_done;
  logic [39:0] div_num;
  logic [23:0] div_den;
  logic [39:0] div_q;

  bgfi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  logic in_xfer;
  logic last_sample;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign last_sample = (sample_count == bgfi_pkg::CntW'(bgfi_pkg::SamplesPerReading - 1));

  // x2 = 2*filt; table points are scaled by the filter scale (a shift).
  logic [20:0] x2;
  logic [20:0] seg_hi_s;
  logic [20:0] seg_lo_s;
  assign x2       = {1'b0, history_sum, 1'b0};
  assign seg_hi_s = 21'(bgfi_pkg::cal_adc(seg + 4'd1)) << $clog2(bgfi_pkg::FilterScale);
  assign seg_lo_s = 21'(bgfi_pkg::cal_adc(seg)) << $clog2(bgfi_pkg::FilterScale);

  // Numerator for the calibration: v_lo*S*dx + (x2 - a_lo*S)*dv, signed.
  logic        cal_batt_sel;
  logic signed [15:0] v_lo, v_hi, dv;
  logic signed [15:0] dx;
  logic signed [22:0] xoff;
  logic signed [41:0] cal_numer;
  logic signed [41:0] cal_abs;
  assign cal_batt_sel = (state == bgfi_pkg::ST_NUM_B);
  assign v_lo = cal_batt_sel ? 16'(bgfi_pkg::cal_batt(seg)) : 16'(bgfi_pkg::cal_sense(seg));
  assign v_hi = cal_batt_sel ? 16'(bgfi_pkg::cal_batt(seg + 4'd1))
                             : 16'(bgfi_pkg::cal_sense(seg + 4'd1));
  assign dv   = v_hi - v_lo;
  assign dx   = 16'(bgfi_pkg::cal_adc(seg + 4'd1)) - 16'(bgfi_pkg::cal_adc(seg));
  assign xoff = $signed({2'b00, x2}) - $signed({2'b00, seg_lo_s});
  // v_lo*S*dx is a small product with a constant shift; xoff*dv is one 23x16.
  assign cal_numer = (42'(v_lo * dx) <<< $clog2(bgfi_pkg::FilterScale))
                   + 42'(xoff * dv);
  assign cal_abs   = cal_numer[41] ? -cal_numer : cal_numer;

  // Percent numerator: pct_lo*dv + (mv - mv_lo)*dp, nonnegative in range.
  logic [12:0] pmv_lo, pmv_hi;
  logic [6:0]  ppc_lo, ppc_hi;
  logic [12:0] pdv;
  logic [6:0]  pdp;
  logic [23:0] pct_numer;
  assign pmv_lo    = bgfi_pkg::curve_mv(pseg - 4'd1);
  assign pmv_hi    = bgfi_pkg::curve_mv(pseg);
  assign ppc_lo    = bgfi_pkg::curve_pct(pseg - 4'd1);
  assign ppc_hi    = bgfi_pkg::curve_pct(pseg);
  assign pdv       = pmv_hi - pmv_lo;
  assign pdp       = ppc_hi - ppc_lo;
  assign pct_numer = 24'(ppc_lo) * 24'(pdv)
                   + 24'(batt_r[12:0] - pmv_lo) * 24'(pdp);

  // Divider operands: (2*num + den) / (2*den).
  logic [23:0] cal_den;
  assign cal_den = {dx[7:0], 16'd0} >> (15 - $clog2(bgfi_pkg::FilterScale));

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      bgfi_pkg::ST_NUM_S, bgfi_pkg::ST_NUM_B: begin
        div_start = 1'b1;
        div_num   = 40'({cal_abs[38:0], 1'b0}) + 40'(cal_den);
        div_den   = {cal_den[22:0], 1'b0};
      end
      bgfi_pkg::ST_PSEG: begin
        // Only a voltage above the lowest curve point and no higher than the top one is interpolated.
        if (!pct_const && (batt_r > $signed(16'(bgfi_pkg::curve_mv(4'd0))))
            && (batt_r <= $signed({3'b000, pmv_hi}))) begin
          div_start = 1'b1;
          div_num   = 40'({pct_numer, 1'b0}) + 40'(pdv);
          div_den   = 24'({pdv, 1'b0});
        end
      end
      default: ;
    endcase
  end

  // Saturation of a divided magnitude with sign.
  function automatic logic signed [15:0] sat_signed(input logic [39:0] q, input logic n);
    if (!n) return (q > 40'd32767) ? 16'sd32767 : 16'(q);
    return (q > 40'd32768) ? -16'sd32768 : -$signed(16'(q));
  endfunction

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      bgfi_pkg::ST_IDLE:
        if (in_xfer && last_sample) state_next = bgfi_pkg::ST_HIST;
      bgfi_pkg::ST_HIST:
        if (primed || fill_idx == bgfi_pkg::PtrW'(bgfi_pkg::HistoryDepth - 1))
          state_next = bgfi_pkg::ST_SEG;
      bgfi_pkg::ST_SEG:
        if (x2 >= (21'(bgfi_pkg::cal_adc(4'(bgfi_pkg::CalPoints - 1)))
                   << $clog2(bgfi_pkg::FilterScale))
            || x2 <= seg_hi_s || seg == 4'(bgfi_pkg::CalPoints - 2))
          state_next = bgfi_pkg::ST_NUM_S;
      bgfi_pkg::ST_NUM_S: state_next = bgfi_pkg::ST_DIV_S;
      bgfi_pkg::ST_DIV_S: if (div_done) state_next = bgfi_pkg::ST_NUM_B;
      bgfi_pkg::ST_NUM_B: state_next = bgfi_pkg::ST_DIV_B;
      bgfi_pkg::ST_DIV_B: if (div_done) state_next = bgfi_pkg::ST_PSEG;
      bgfi_pkg::ST_PSEG:
        if (pct_const) state_next = bgfi_pkg::ST_OUT;
        else if (div_start) state_next = bgfi_pkg::ST_PDIV;
      bgfi_pkg::ST_PDIV: if (div_done) state_next = bgfi_pkg::ST_OUT;
      bgfi_pkg::ST_OUT:
        if (out_ch.ready) state_next = bgfi_pkg::ST_IDLE;
      default: state_next = bgfi_pkg::ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    in_ch.ready = (state == bgfi_pkg::ST_IDLE);
    out_valid   = (state == bgfi_pkg::ST_OUT);
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.filtered_adc   = history_sum;
  assign out_ch.sense_mv       = sense_r;
  assign out_ch.battery_mv     = batt_r;
  assign out_ch.charge_percent = pct_r;
  assign out_ch.reading_number = reading_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= bgfi_pkg::ST_IDLE;
      sample_sum      <= '0;
      sample_count    <= '0;
      history_sum     <= '0;
      history_pointer <= '0;
      primed          <= 1'b0;
      reading_counter <= '0;
      fill_idx        <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        bgfi_pkg::ST_IDLE: begin
          if (in_xfer) begin
            if (last_sample) begin
              reading      <= sample_sum + 16'(in_ch.adc_sample_mv);
              sample_sum   <= '0;
              sample_count <= '0;
              fill_idx     <= '0;
            end else begin
              sample_sum   <= sample_sum + 16'(in_ch.adc_sample_mv);
              sample_count <= sample_count + bgfi_pkg::CntW'(1);
            end
          end
        end
        bgfi_pkg::ST_HIST: begin
          seg <= '0;
          if (primed) begin
            reading_history[history_pointer] <= reading;
            history_sum <= history_sum - 19'(reading_history[history_pointer])
                         + 19'(reading);
            history_pointer <= history_pointer + bgfi_pkg::PtrW'(1);
          end else begin
            reading_history[fill_idx] <= reading;
            fill_idx <= fill_idx + bgfi_pkg::PtrW'(1);
            history_sum <= 19'(reading) << bgfi_pkg::PtrW;
            history_pointer <= '0;
          end
        end
        bgfi_pkg::ST_SEG: begin
          if (x2 >= (21'(bgfi_pkg::cal_adc(4'(bgfi_pkg::CalPoints - 1)))
                     << $clog2(bgfi_pkg::FilterScale))) begin
            seg <= 4'(bgfi_pkg::CalPoints - 2);
          end else if (!(x2 <= seg_hi_s) && seg != 4'(bgfi_pkg::CalPoints - 2)) begin
            seg <= seg + 4'd1;
          end
        end
        bgfi_pkg::ST_NUM_S, bgfi_pkg::ST_NUM_B: neg <= cal_numer[41];
        bgfi_pkg::ST_DIV_S: if (div_done) sense_r <= sat_signed(div_q, neg);
        bgfi_pkg::ST_DIV_B: begin
          if (div_done) begin
            batt_r <= sat_signed(div_q, neg);
            pseg   <= 4'd1;
            pct_const <= 1'b0;
            primed <= 1'b1;
            reading_counter <= reading_counter + 32'd1;
          end
        end
        bgfi_pkg::ST_PSEG: begin
          if (batt_r <= $signed(16'(bgfi_pkg::curve_mv(4'd0)))) begin
            pct_r <= 7'd0;
            pct_const <= 1'b1;
          end else if (!(batt_r <= $signed({3'b000, pmv_hi}))) begin
            if (pseg == 4'(bgfi_pkg::CurvePoints - 1)) begin
              pct_r <= 7'd100;
              pct_const <= 1'b1;
            end else begin
              pseg <= pseg + 4'd1;
            end
          end
        end
        bgfi_pkg::ST_PDIV: if (div_done) pct_r <= div_q[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/bgfi_div.sv =====
// ----------------------------------------------------------------------------
// bgfi_div: shared restoring divider, one quotient bit per cycle.
// Divides a nonnegative 40-bit dividend by a 24-bit divisor.
// ----------------------------------------------------------------------------
module bgfi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [39:0] quotient
);

  logic [5:0]  count;
  logic        busy;
  logic [24:0] rem;
  logic [39:0] quo;
  logic [23:0] dvs;
  logic [24:0] trial;
  logic [24:0] shifted;

  assign shifted = {rem[23:0], quo[39]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd40;
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        if (trial[24]) begin
          rem <= shifted;
          quo <= {quo[38:0], 1'b0};
        end else begin
          rem <= trial;
          quo <= {quo[38:0], 1'b1};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/core/bgfi_checker.sv =====
// ----------------------------------------------------------------------------
// bgfi_checker: port-level checks for the battery gauge.
// Watches the two channels and the reading count over time.
// ----------------------------------------------------------------------------
module bgfi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] reading_number,
  input logic [6:0]  charge_percent
);

  // No sample is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(in_valid && in_ready)) else $error("sample taken while result pending");

  // A result offered stays offered until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // Percentages never exceed full charge.
  a_pct: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> charge_percent <= 7'd100) else $error("percent out of range");

  // The reading number only ever steps up by one.
  a_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && reading_number != $past(reading_number)
    |-> reading_number == $past(reading_number) + 32'd1)
    else $error("reading number skipped");

endmodule

bind battery_gauge_filter_interp bgfi_checker u_bgfi_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .reading_number (out_ch.reading_number),
  .charge_percent (out_ch.charge_percent)
);
